// ===== rtl/core/stexq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted expiry timer queue: shared package
// Request and status codes, controller states and the cell control types.
// ----------------------------------------------------------------------------
package stexq_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NONE_DUE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PLACE,
    S_POP
  } state_t;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEW,
    CELL_LEFT,
    CELL_RIGHT
  } cell_mode_t;

  // Compare results of one cell against the broadcast key.
  typedef struct packed {
    logic match;
    logic later;
  } cell_flags_t;

endpackage

// ===== rtl/core/stexq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted expiry timer queue: storage cell
// Holds one timer, compares it with the broadcast key and shifts toward
// either neighbor on command.
// ----------------------------------------------------------------------------
module stexq_cell #(
  parameter int unsigned ID_WIDTH   = 12,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk,
  input  stexq_pkg::cell_mode_t  mode,
  input  logic [ID_WIDTH-1:0]    key_id,
  input  logic [TIME_WIDTH-1:0]  key_time,
  input  logic [ID_WIDTH-1:0]    left_id,
  input  logic [TIME_WIDTH-1:0]  left_expiry,
  input  logic [ID_WIDTH-1:0]    right_id,
  input  logic [TIME_WIDTH-1:0]  right_expiry,
  output logic [ID_WIDTH-1:0]    id,
  output logic [TIME_WIDTH-1:0]  expiry,
  output stexq_pkg::cell_flags_t flags
);
  import stexq_pkg::*;

  always_ff @(posedge clk) begin
    case (mode)
      CELL_NEW: begin
        id     <= key_id;
        expiry <= key_time;
      end
      CELL_LEFT: begin
        id     <= left_id;
        expiry <= left_expiry;
      end
      CELL_RIGHT: begin
        id     <= right_id;
        expiry <= right_expiry;
      end
      default: begin
        id     <= id;
        expiry <= expiry;
      end
    endcase
  end

  assign flags.match = (id == key_id);
  assign flags.later = (expiry > key_time);

endmodule

// ===== rtl/core/sorted_expiry_timer_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted expiry timer queue
// Insert, adjust, delete and expiry tick on a sorted row of timer cells.
// ----------------------------------------------------------------------------
// Insert and delete register their result from the execute state; an adjust removes
// its timer there and files it again in the place state, which registers its result.
// A tick registers one result per cycle for each popped timer while the output is free,
// or a single none-due result; a new request is taken only once the controller is idle.
// A stalled output holds the controller in its current state.
// Reset empties the queue at once; cell contents are never cleared.
module sorted_expiry_timer_queue_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ID_WIDTH   = 12,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic                                                s_axis_tvalid,
  output logic                                                s_axis_tready,
  // req_type, timer_id, expire_time, now_time (lowest bits first)
  input  logic [((stexq_pkg::REQ_W+ID_WIDTH+2*TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                                m_axis_tvalid,
  input  logic                                                m_axis_tready,
  // timer_id_res, status (lowest bits first)
  output logic [((ID_WIDTH+stexq_pkg::STATUS_W+7)/8)*8-1:0]   m_axis_tdata,
  // expired
  output logic                                                m_axis_tuser,
  output logic                                                m_axis_tlast
);
  import stexq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OUT_DW = ((ID_WIDTH + STATUS_W + 7) / 8) * 8;

  state_t                 state, state_next;
  req_t                   req_type;
  logic [ID_WIDTH-1:0]    req_id;
  logic [TIME_WIDTH-1:0]  req_exp;
  logic [TIME_WIDTH-1:0]  req_now;
  logic [TIME_WIDTH-1:0]  key_time;
  logic [CNT_W-1:0]       count, count_next;

  logic [ID_WIDTH-1:0]    cell_id     [DEPTH];
  logic [TIME_WIDTH-1:0]  cell_expiry [DEPTH];
  cell_flags_t            cell_flags  [DEPTH];
  cell_mode_t             cell_mode   [DEPTH];

  logic [DEPTH-1:0]       occ, match_v, later_v, pre_match;
  logic                   any_match, full, out_free, pop_ok;

  logic                   out_load;
  logic                   out_expired;
  logic [ID_WIDTH-1:0]    out_id;
  status_t                out_status;
  logic                   out_last;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [ID_WIDTH-1:0]   l_id, r_id;
      logic [TIME_WIDTH-1:0] l_exp, r_exp;
      if (g == 0) begin : g_first
        assign l_id  = req_id;
        assign l_exp = key_time;
      end else begin : g_inner_l
        assign l_id  = cell_id[g-1];
        assign l_exp = cell_expiry[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign r_id  = cell_id[g];
        assign r_exp = cell_expiry[g];
      end else begin : g_inner_r
        assign r_id  = cell_id[g+1];
        assign r_exp = cell_expiry[g+1];
      end
      stexq_cell #(
        .ID_WIDTH   (ID_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
        .clk          (clk),
        .mode         (cell_mode[g]),
        .key_id       (req_id),
        .key_time     (key_time),
        .left_id      (l_id),
        .left_expiry  (l_exp),
        .right_id     (r_id),
        .right_expiry (r_exp),
        .id           (cell_id[g]),
        .expiry       (cell_expiry[g]),
        .flags        (cell_flags[g])
      );
      assign occ[g]     = (CNT_W'(g) < count);
      assign match_v[g] = occ[g] & cell_flags[g].match;
      assign later_v[g] = occ[g] & cell_flags[g].later;
    end
  endgenerate

  assign key_time  = (req_type == REQ_TICK) ? req_now : req_exp;
  assign any_match = |match_v;
  assign full      = (count == CNT_W'(DEPTH));
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign pop_ok    = occ[0] & ~cell_flags[0].later;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    pre_match[0] = match_v[0];
    for (int i = 1; i < DEPTH; i++) begin
      pre_match[i] = pre_match[i-1] | match_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_type <= req_t'(s_axis_tdata[REQ_W-1:0]);
      req_id   <= s_axis_tdata[REQ_W +: ID_WIDTH];
      req_exp  <= s_axis_tdata[REQ_W+ID_WIDTH +: TIME_WIDTH];
      req_now  <= s_axis_tdata[REQ_W+ID_WIDTH+TIME_WIDTH +: TIME_WIDTH];
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    out_load    = 1'b0;
    out_expired = 1'b0;
    out_id      = req_id;
    out_status  = ST_OK;
    out_last    = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      cell_mode[i] = CELL_HOLD;
    end
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (req_t'(s_axis_tdata[REQ_W-1:0]) == REQ_TICK) ? S_POP : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          out_load   = 1'b1;
          if (req_type == REQ_INSERT) begin
            if (any_match) begin
              out_status = ST_DUPLICATE;
            end else if (full) begin
              out_status = ST_FULL;
            end else begin
              count_next = count + 1'b1;
              for (int i = 0; i < DEPTH; i++) begin
                if (i > 0 && later_v[(i > 0) ? i - 1 : 0]) begin
                  cell_mode[i] = CELL_LEFT;
                end else if (later_v[i] || (!occ[i] && (i == 0 || occ[(i > 0) ? i - 1 : 0])))
                begin
                  cell_mode[i] = CELL_NEW;
                end
              end
            end
          end else if (!any_match) begin
            out_status = ST_NOT_FOUND;
          end else begin
            count_next = count - 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              if (pre_match[i]) begin
                cell_mode[i] = CELL_RIGHT;
              end
            end
            if (req_type == REQ_ADJUST) begin
              out_load   = 1'b0;
              state_next = S_PLACE;
            end
          end
        end
      end
      S_PLACE: begin
        if (out_free) begin
          state_next = S_IDLE;
          out_load   = 1'b1;
          count_next = count + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (i > 0 && later_v[(i > 0) ? i - 1 : 0]) begin
              cell_mode[i] = CELL_LEFT;
            end else if (later_v[i] || (!occ[i] && (i == 0 || occ[(i > 0) ? i - 1 : 0]))) begin
              cell_mode[i] = CELL_NEW;
            end
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pop_ok) begin
            out_expired = 1'b1;
            out_id      = cell_id[0];
            out_last    = !(occ[1] && !cell_flags[1].later);
            count_next  = count - 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              cell_mode[i] = CELL_RIGHT;
            end
            if (out_last) begin
              state_next = S_IDLE;
            end
          end else begin
            out_status = ST_NONE_DUE;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_DW'({out_status, out_id});
      m_axis_tuser <= out_expired;
      m_axis_tlast <= out_last;
    end
  end

endmodule

// ===== tb/timer_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted expiry timer queue: result checker
// Watches both stream channels of the timer queue. Every accepted request
// updates a private sorted timer list and queues the results it must cause.
// Every accepted result is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module timer_queue_checker #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ID_WIDTH   = 12,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic                                                s_tvalid,
  input  logic                                                s_tready,
  // req_type, timer_id, expire_time, now_time (lowest bits first)
  input  logic [((stexq_pkg::REQ_W+ID_WIDTH+2*TIME_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                                                m_tvalid,
  input  logic                                                m_tready,
  // timer_id_res, status (lowest bits first)
  input  logic [((ID_WIDTH+stexq_pkg::STATUS_W+7)/8)*8-1:0]   m_tdata,
  // expired
  input  logic                                                m_tuser,
  input  logic                                                m_tlast,
  output int                                                  fail_count,
  output int                                                  pending,
  output int                                                  results_seen,
  output int                                                  expired_seen,
  output logic [7:0]                                          status_seen
);
  import stexq_pkg::*;

  localparam int unsigned ID_LSB  = REQ_W;
  localparam int unsigned EXP_LSB = REQ_W + ID_WIDTH;
  localparam int unsigned NOW_LSB = REQ_W + ID_WIDTH + TIME_WIDTH;

  typedef struct {
    logic                expired;
    logic [ID_WIDTH-1:0] id;
    status_t             status;
    logic                last;
  } timer_result_t;

  logic [TIME_WIDTH-1:0] due_at [DEPTH];
  logic [ID_WIDTH-1:0]   owner  [DEPTH];
  int unsigned           live;
  timer_result_t         awaited_results [$];

  function automatic int find_timer(logic [ID_WIDTH-1:0] id);
    for (int i = 0; i < int'(live); i++) begin
      if (owner[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void unlink_timer(int pos);
    for (int i = pos; i + 1 < int'(live); i++) begin
      due_at[i] = due_at[i+1];
      owner[i]  = owner[i+1];
    end
    live--;
  endfunction

  // Timers with an equal expiry keep the order in which they were filed.
  function automatic void file_timer(logic [ID_WIDTH-1:0] id, logic [TIME_WIDTH-1:0] due);
    int pos;
    pos = 0;
    while (pos < int'(live) && due_at[pos] <= due) pos++;
    for (int i = int'(live); i > pos; i--) begin
      due_at[i] = due_at[i-1];
      owner[i]  = owner[i-1];
    end
    due_at[pos] = due;
    owner[pos]  = id;
    live++;
  endfunction

  function automatic void await_result(logic expired, logic [ID_WIDTH-1:0] id,
                                       status_t status, logic last);
    timer_result_t r;
    r.expired = expired;
    r.id      = id;
    r.status  = status;
    r.last    = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_request(req_t req, logic [ID_WIDTH-1:0] id,
                                          logic [TIME_WIDTH-1:0] due,
                                          logic [TIME_WIDTH-1:0] now);
    int pos;
    int popped;
    timer_result_t tail;
    case (req)
      REQ_INSERT: begin
        if (find_timer(id) >= 0) begin
          await_result(1'b0, id, ST_DUPLICATE, 1'b1);
        end else if (live == DEPTH) begin
          await_result(1'b0, id, ST_FULL, 1'b1);
        end else begin
          file_timer(id, due);
          await_result(1'b0, id, ST_OK, 1'b1);
        end
      end
      REQ_ADJUST, REQ_DELETE: begin
        pos = find_timer(id);
        if (pos < 0) begin
          await_result(1'b0, id, ST_NOT_FOUND, 1'b1);
        end else begin
          unlink_timer(pos);
          if (req == REQ_ADJUST) file_timer(id, due);
          await_result(1'b0, id, ST_OK, 1'b1);
        end
      end
      default: begin
        popped = 0;
        while (live > 0 && due_at[0] <= now) begin
          await_result(1'b1, owner[0], ST_OK, 1'b0);
          unlink_timer(0);
          popped++;
        end
        if (popped == 0) begin
          await_result(1'b0, id, ST_NONE_DUE, 1'b1);
        end else begin
          tail = awaited_results.pop_back();
          tail.last = 1'b1;
          awaited_results.push_back(tail);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    expired_seen = 0;
    status_seen  = '0;
    live         = 0;
  end

  always @(posedge clk) begin : watch
    timer_result_t want;
    logic [STATUS_W-1:0] got_status;
    if (rst) begin
      live = 0;
      awaited_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_request(req_t'(s_tdata[REQ_W-1:0]), s_tdata[ID_LSB +: ID_WIDTH],
                        s_tdata[EXP_LSB +: TIME_WIDTH], s_tdata[NOW_LSB +: TIME_WIDTH]);
      end
      if (m_tvalid && m_tready) begin
        got_status = m_tdata[ID_WIDTH +: STATUS_W];
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unrequested result, expected none, actual expired %0b id %0d status %0d last %0b",
                   $time, m_tuser, m_tdata[ID_WIDTH-1:0], got_status, m_tlast);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("expired", want.expired, m_tuser);
          check_field("timer_id_res", want.id, m_tdata[ID_WIDTH-1:0]);
          check_field("status", want.status, got_status);
          check_field("last", want.last, m_tlast);
        end
        results_seen++;
        if (m_tuser) expired_seen++;
        status_seen[got_status] = 1'b1;
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== tb/tb_sorted_expiry_timer_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted expiry timer queue: testbench top
// Drives directed and random timer requests with random gaps and output
// stalls, including one long output hold-off, and reports the verdict from
// the checker that runs beside the queue.
// ----------------------------------------------------------------------------
module tb_sorted_expiry_timer_queue_core;
  import stexq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ID_WIDTH    = 12;
  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned IN_W        = ((REQ_W + ID_WIDTH + 2*TIME_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((ID_WIDTH + STATUS_W + 7) / 8) * 8;
  localparam int unsigned ID_LSB      = REQ_W;
  localparam int unsigned EXP_LSB     = REQ_W + ID_WIDTH;
  localparam int unsigned NOW_LSB     = REQ_W + ID_WIDTH + TIME_WIDTH;
  localparam int          ITEMS_PER_PHASE = 28;
  localparam int          HOLD_CYCLES = 90;
  localparam int          DRAIN       = 20;
  localparam int          CYCLE_LIMIT = 300000;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  int                fail_count;
  int                pending;
  int                results_seen;
  int                expired_seen;
  logic [7:0]        status_seen;

  logic              tx_idle;
  logic              rx_idle;
  logic              hold_rx;
  int                requests_sent;
  int                directed_count;
  logic [TIME_WIDTH-1:0] clock_now;
  logic [ID_WIDTH-1:0]   id_pool [24];

  sorted_expiry_timer_queue_core #(
    .DEPTH(DEPTH), .ID_WIDTH(ID_WIDTH), .TIME_WIDTH(TIME_WIDTH)
  ) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  timer_queue_checker #(
    .DEPTH(DEPTH), .ID_WIDTH(ID_WIDTH), .TIME_WIDTH(TIME_WIDTH)
  ) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
    .m_tuser(m_axis_tuser), .m_tlast(m_axis_tlast),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .expired_seen(expired_seen), .status_seen(status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IN_W-1:0] pack_req(req_t req, logic [ID_WIDTH-1:0] id,
                                               logic [TIME_WIDTH-1:0] due,
                                               logic [TIME_WIDTH-1:0] now);
    logic [IN_W-1:0] word;
    word = '0;
    word[REQ_W-1:0]              = req;
    word[ID_LSB +: ID_WIDTH]     = id;
    word[EXP_LSB +: TIME_WIDTH]  = due;
    word[NOW_LSB +: TIME_WIDTH]  = now;
    return word;
  endfunction

  // Mostly ids from a small pool so that duplicates, hits and a full table
  // are common; time moves forward so that ticks pop part of the queue.
  function automatic logic [IN_W-1:0] random_req();
    int r;
    logic [ID_WIDTH-1:0]   id;
    logic [TIME_WIDTH-1:0] due;
    logic [TIME_WIDTH-1:0] now;
    r   = $urandom_range(0, 99);
    id  = ($urandom_range(0, 19) == 0) ? ID_WIDTH'($urandom) : id_pool[$urandom_range(0, 23)];
    now = TIME_WIDTH'($urandom);
    case ($urandom_range(0, 9))
      0:       due = TIME_WIDTH'($urandom);
      1:       due = clock_now;
      default: due = clock_now + TIME_WIDTH'(10 * $urandom_range(0, 30));
    endcase
    if (r < 42) return pack_req(REQ_INSERT, id, due, now);
    if (r < 62) return pack_req(REQ_ADJUST, id, due, now);
    if (r < 75) return pack_req(REQ_DELETE, id, due, now);
    clock_now = clock_now + TIME_WIDTH'($urandom_range(0, 120));
    r = $urandom_range(0, 99);
    if (r < 4) now = '1;
    else if (r >= 8) now = clock_now;
    return pack_req(REQ_TICK, ID_WIDTH'($urandom), due, now);
  endfunction

  task automatic send_req(input logic [IN_W-1:0] word);
    int gap;
    s_axis_tdata  = word;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    @(negedge clk);
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin : receiver
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
        m_axis_tready = 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        stall = 1 + pick_gap();
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_rx       = 1'b0;
    requests_sent = 0;
    clock_now     = TIME_WIDTH'(1000);
    foreach (id_pool[k]) id_pool[k] = ID_WIDTH'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queue, unknown ids, field extremes and stable order on ties.
    send_req(pack_req(REQ_TICK,   12'hABC, '1, '0));
    send_req(pack_req(REQ_DELETE, 12'h555, '0, '1));
    send_req(pack_req(REQ_ADJUST, 12'hAAA, '0, '0));
    send_req(pack_req(REQ_INSERT, 12'h000, '0, '1));
    send_req(pack_req(REQ_INSERT, 12'hFFF, '1, '0));
    send_req(pack_req(REQ_INSERT, 12'h005, 32'd100, '0));
    send_req(pack_req(REQ_INSERT, 12'h006, 32'd100, '0));
    send_req(pack_req(REQ_ADJUST, 12'h005, 32'd100, '0));
    send_req(pack_req(REQ_TICK,   12'h123, '0, 32'd100));
    // Fill the table, then overflow it, with a duplicate on a full table.
    for (int k = 0; k < 15; k++) begin
      send_req(pack_req(REQ_INSERT, ID_WIDTH'(16 + k), TIME_WIDTH'(200 + 10 * (k % 5)), '0));
    end
    send_req(pack_req(REQ_INSERT, 12'd31, 32'd50, '0));
    send_req(pack_req(REQ_INSERT, 12'd20, 32'd50, '0));
    send_req(pack_req(REQ_ADJUST, 12'hFFF, 32'd150, '0));
    send_req(pack_req(REQ_DELETE, 12'd18, '0, '0));
    send_req(pack_req(REQ_INSERT, 12'd40, '1, '0));
    send_req(pack_req(REQ_TICK,   12'h000, '0, '1));
    directed_count = requests_sent;

    repeat (ITEMS_PER_PHASE) send_req(random_req());

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (ITEMS_PER_PHASE) send_req(random_req());

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
      if (k == 4) begin
        hold_rx = 1'b1;
        tx_idle = 1'b0;
      end
      if (k == 14) tx_idle = 1'b1;
      send_req(random_req());
    end
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Sent %0d requests (%0d directed); checked %0d results, %0d of them expired timers.",
             requests_sent, directed_count, results_seen, expired_seen);
    $display("Status codes returned, one bit per code from the lowest: %b", status_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
